### src/cpb_pkg.sv
`timescale 1ns / 1ps

package cpb_pkg;

    localparam int PatW    = 8;
    localparam int CountW  = 8;
    localparam int PeriodW = 16;
    localparam int PhaseW  = 9;

    localparam logic [PeriodW-1:0] PeriodReset = 16'd250;
    localparam logic [PeriodW-1:0] TicksMax    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [PatW-1:0] lights;
        logic            lights_write;
        logic            blinking;
        logic            last_result;
    } result_t;

    // All results caused by one input item; the second is used only when two is set.
    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } res_pair_t;

    // Command item as held in the input register.
    typedef struct packed {
        op_t                opcode;
        logic [PatW-1:0]    first_pattern;
        logic [PatW-1:0]    second_pattern;
        logic [CountW-1:0]  blink_count;
        logic [PeriodW-1:0] period_ticks;
        logic [PatW-1:0]    end_pattern;
    } cmd_t;

endpackage

### src/cpb_core.sv
`timescale 1ns / 1ps

module cpb_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  cpb_pkg::cmd_t      cmd,
    output cpb_pkg::res_pair_t pair
);
    import cpb_pkg::*;

    logic               active_reg, active_next;
    logic               phase_reg, phase_next;
    logic [PatW-1:0]    first_reg, first_next;
    logic [PatW-1:0]    second_reg, second_next;
    logic [PatW-1:0]    end_reg, end_next;
    logic [PhaseW-1:0]  phases_reg, phases_next;
    logic [PeriodW-1:0] period_reg, period_next;
    logic [PeriodW-1:0] ticks_reg, ticks_next;

    always_comb
    begin
        logic [PeriodW-1:0] ticks_inc;
        logic [PhaseW-1:0]  phases_dec;
        logic [PatW-1:0]    shown;

        active_next = active_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        end_next    = end_reg;
        phases_next = phases_reg;
        period_next = period_reg;
        ticks_next  = ticks_reg;

        ticks_inc  = (ticks_reg == TicksMax) ? ticks_reg : ticks_reg + 1'b1;
        phases_dec = phases_reg - 1'b1;
        shown      = (!phase_reg) ? second_reg : first_reg;

        pair.two  = 1'b0;
        pair.res0 = '{lights: '0, lights_write: 1'b0, blinking: active_reg, last_result: 1'b1};
        pair.res1 = '{lights: end_reg, lights_write: 1'b1, blinking: 1'b0, last_result: 1'b1};

        case (cmd.opcode)
            OP_START:
            begin
                if (cmd.blink_count == '0)
                begin
                    active_next = 1'b0;
                    pair.res0   = '{lights: cmd.end_pattern, lights_write: 1'b1,
                                    blinking: 1'b0, last_result: 1'b1};
                end
                else
                begin
                    first_next  = cmd.first_pattern;
                    second_next = cmd.second_pattern;
                    end_next    = cmd.end_pattern;
                    period_next = cmd.period_ticks;
                    phases_next = {cmd.blink_count, 1'b0};
                    active_next = 1'b1;
                    phase_next  = 1'b0;
                    ticks_next  = '0;
                    pair.res0   = '{lights: cmd.first_pattern, lights_write: 1'b1,
                                    blinking: 1'b1, last_result: 1'b1};
                end
            end
            OP_CANCEL:
            begin
                active_next        = 1'b0;
                pair.res0.blinking = 1'b0;
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    if (ticks_inc < period_reg)
                    begin
                        ticks_next = ticks_inc;
                    end
                    else
                    begin
                        ticks_next  = '0;
                        phase_next  = ~phase_reg;
                        phases_next = phases_dec;
                        if (phases_dec == '0)
                        begin
                            active_next = 1'b0;
                            pair.two    = 1'b1;
                            pair.res0   = '{lights: shown, lights_write: 1'b1,
                                            blinking: 1'b0, last_result: 1'b0};
                        end
                        else
                        begin
                            pair.res0 = '{lights: shown, lights_write: 1'b1,
                                          blinking: 1'b1, last_result: 1'b1};
                        end
                    end
                end
            end
            default:
            begin
                // Unused opcode: report the current state and change nothing.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
            end_reg    <= '0;
            phases_reg <= '0;
            period_reg <= PeriodReset;
            ticks_reg  <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            end_reg    <= end_next;
            phases_reg <= phases_next;
            period_reg <= period_next;
            ticks_reg  <= ticks_next;
        end
    end

endmodule

### src/cpb_out_queue.sv
`timescale 1ns / 1ps

module cpb_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cpb_pkg::res_pair_t push_pair,
    output logic               can_push,
    output logic               out_valid,
    input  logic               out_ready,
    output cpb_pkg::result_t   head
);
    import cpb_pkg::*;

    // Two entries, each holding all results of one item.
    res_pair_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       sub_reg;
    logic       xfer;
    logic       pop;
    res_pair_t  head_pair;

    assign head_pair = entry_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign can_push  = (count_reg != 2'd2);
    assign head      = sub_reg ? head_pair.res1 : head_pair.res0;
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && (!head_pair.two || sub_reg);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                sub_reg    <= 1'b0;
            end
            else if (xfer)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

endmodule

### src/counted_pattern_blinker.sv
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// input    in_valid / in_ready     opcode, two patterns, blink_count, period_ticks, end_pattern
// output   out_valid / out_ready   lights, lights_write, blinking, last_result
//
// An item is taken into the input register; once the queue has a free entry, the blinker
// state is updated and its one or two results are written into a two-entry result queue.
// Sustained rate is one item per cycle while out_ready is high and each item gives one result;
// an item that ends a blink sequence gives two results, which leave the output port in turn.
// Reset clears all control state, the stored patterns and counters, and sets the period
// to 250 ticks.
// A stalled output side fills the queue, which then holds the input register, which
// then drops in_ready.
module counted_pattern_blinker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [cpb_pkg::PatW-1:0]    first_pattern,
    input  logic [cpb_pkg::PatW-1:0]    second_pattern,
    input  logic [cpb_pkg::CountW-1:0]  blink_count,
    input  logic [cpb_pkg::PeriodW-1:0] period_ticks,
    input  logic [cpb_pkg::PatW-1:0]    end_pattern,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cpb_pkg::PatW-1:0]    lights,
    output logic                        lights_write,
    output logic                        blinking,
    output logic                        last_result
);
    import cpb_pkg::*;

    // Input register: holds one command until the core has taken it.
    logic      in_vld_reg;
    cmd_t      cmd_reg;
    logic      step;
    logic      can_push;
    res_pair_t pair;
    result_t   head;

    // The core advances whenever a command is held and the queue has a free entry.
    assign step     = in_vld_reg && can_push;
    assign in_ready = !in_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Payload needs no reset; it is qualified by in_vld_reg.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg.opcode         <= op_t'(opcode);
            cmd_reg.first_pattern  <= first_pattern;
            cmd_reg.second_pattern <= second_pattern;
            cmd_reg.blink_count    <= blink_count;
            cmd_reg.period_ticks   <= period_ticks;
            cmd_reg.end_pattern    <= end_pattern;
        end
    end

    cpb_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_reg),
        .pair  (pair)
    );

    cpb_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_pair (pair),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign lights       = head.lights;
    assign lights_write = head.lights_write;
    assign blinking     = head.blinking;
    assign last_result  = head.last_result;

endmodule
